### design/pwsg_pkg.sv
// shared constants, codes and types for the periodic waveform sample generator
// no dependencies; used by pwsg_sine_rom and periodic_waveform_sample_generator_top
package pwsg_pkg;

    // default geometry of the sine table
    localparam int unsigned DEF_SAMPLES   = 256;
    localparam int unsigned DEF_FRAC_BITS = 16;

    // field widths
    localparam int unsigned CODE_W  = 12;
    localparam int unsigned RES_W   = 4;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned KIND_W  = 2;

    // configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_RES    = 1'b0;

    // resolution register
    localparam logic [RES_W-1:0] RES_RESET = 4'd8;
    localparam logic [RES_W-1:0] RES_MIN   = 4'd1;
    localparam logic [RES_W-1:0] RES_MAX   = 4'd12;

    // waveform kinds
    localparam logic [KIND_W-1:0] KIND_SINE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRI    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SAW    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd3;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [KIND_W-1:0] t_kind;

endpackage

### design/pwsg_sine_rom.sv
// sine table rom, one entry per sample of the period, registered read
// depends on pwsg_pkg for defaults; contents built at elaboration
module pwsg_sine_rom #(
    parameter int unsigned SAMPLES   = pwsg_pkg::DEF_SAMPLES,
    parameter int unsigned FRAC_BITS = pwsg_pkg::DEF_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(SAMPLES)-1:0] i_rd_addr,
    output logic [FRAC_BITS-1:0]       o_rd_data
);

    localparam int unsigned  QUARTER  = SAMPLES / 4;
    localparam logic [63:0]  HALF_PI  = 64'd1686629713;
    localparam logic [63:0]  ONE      = 64'd1 << 30;
    localparam int unsigned  TERMS    = 13;
    localparam logic [63:0]  TAYLOR_DIV [TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    // Q0.F entry: quarter wave by Taylor series in Q2.30, folded to a full period
    function automatic logic [FRAC_BITS-1:0] sine_entry(input int unsigned idx);
        logic [63:0] quad;
        logic [63:0] k;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] v;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] top;
        int          t;
        quad = 64'(idx / QUARTER);
        k    = 64'(idx % QUARTER);
        m    = quad[0] ? (64'(QUARTER) - k) : k;
        if (m == 64'd0) begin
            v = 64'd0;
        end else if (m >= 64'(QUARTER)) begin
            v = ONE;
        end else begin
            x    = (HALF_PI * m) / QUARTER;
            x2   = (x * x) >> 30;
            term = x;
            pos  = x;
            neg  = 64'd0;
            for (t = 0; t < TERMS; t++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[t];
                if (t[0] == 1'b0) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            if (neg >= pos) begin
                v = 64'd0;
            end else begin
                v = pos - neg;
                if (v > ONE) begin
                    v = ONE;
                end
            end
        end
        u   = quad[1] ? (ONE - v) : (ONE + v);
        s   = (u + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
        top = (64'd1 << FRAC_BITS) - 64'd1;
        if (s > top) begin
            s = top;
        end
        return FRAC_BITS'(s);
    endfunction

    logic [FRAC_BITS-1:0] w_tab [SAMPLES];

    // constant contents
    for (genvar g = 0; g < SAMPLES; g++) begin : g_tab
        assign w_tab[g] = sine_entry(g);
    end

    // synchronous read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= w_tab[i_rd_addr];
        end
    end

endmodule

### design/periodic_waveform_sample_generator_top.sv
// periodic waveform sample generator: sine, triangle, sawtooth and square codes
// input passes stage 1, stage 2 and output registers; one transaction per cycle
// when not stalled; the rom read is registered and there is one multiplier stage
// synchronous active-low reset clears the pipeline valids and sets resolution to 8
// depends on pwsg_pkg and pwsg_sine_rom
module periodic_waveform_sample_generator_top #(
    parameter int unsigned SAMPLES_PER_PERIOD = pwsg_pkg::DEF_SAMPLES,
    parameter int unsigned SINE_FRACTION_BITS = pwsg_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pwsg_pkg::KIND_W-1:0]        i_wave_kind,
    input  logic [pwsg_pkg::INDEX_W-1:0]       i_sample_index,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pwsg_pkg::CODE_W-1:0]        o_sample_code,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pwsg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pwsg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pwsg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int unsigned IDX_W  = $clog2(SAMPLES_PER_PERIOD);
    localparam int unsigned EXT_W  = IDX_W + pwsg_pkg::INDEX_W;
    localparam int unsigned OPB_W  = (SINE_FRACTION_BITS > IDX_W) ? SINE_FRACTION_BITS : IDX_W;
    localparam int unsigned PROD_W = pwsg_pkg::CODE_W + OPB_W;
    localparam int unsigned FULL_W = pwsg_pkg::CODE_W + 1;
    localparam logic [PROD_W:0]  SINE_HALF = (PROD_W + 1)'(1) << (SINE_FRACTION_BITS - 1);
    localparam logic [IDX_W:0]   PERIOD    = (IDX_W + 1)'(SAMPLES_PER_PERIOD);

    // configuration register
    logic [pwsg_pkg::RES_W-1:0] r_res_bits;
    logic                       w_reg_idx;

    assign w_reg_idx = paddr[pwsg_pkg::APB_ADDR_W-1];
    assign pready    = 1'b1;
    assign prdata    = (w_reg_idx == pwsg_pkg::REG_RES) ?
                       pwsg_pkg::APB_DATA_W'(r_res_bits) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_bits <= pwsg_pkg::RES_RESET;
        end else if (psel && penable && pwrite && pready && w_reg_idx == pwsg_pkg::REG_RES) begin
            r_res_bits <= pwdata[pwsg_pkg::RES_W-1:0];
        end
    end

    // pipeline registers
    logic                   r_s1_valid;
    pwsg_pkg::t_kind        r_s1_kind;
    logic [IDX_W-1:0]       r_s1_idx;
    pwsg_pkg::t_code        r_s1_full;
    logic                   r_s2_valid;
    pwsg_pkg::t_kind        r_s2_kind;
    logic                   r_s2_upper;
    pwsg_pkg::t_code        r_s2_full;
    logic [PROD_W-1:0]      r_s2_prod;
    logic                   r_out_valid;
    pwsg_pkg::t_code        r_out_code;

    // per-stage advance, bubbles collapse
    logic w_rdy3;
    logic w_rdy2;
    logic w_rdy1;

    assign w_rdy3     = !r_out_valid || !i_out_stall;
    assign w_rdy2     = !r_s2_valid || w_rdy3;
    assign w_rdy1     = !r_s1_valid || w_rdy2;
    assign o_in_stall = !w_rdy1;

    // full scale code from the clamped resolution
    logic [pwsg_pkg::RES_W-1:0] w_eff_bits;
    pwsg_pkg::t_code            n_full;
    logic [EXT_W-1:0]           w_idx_ext;

    always_comb begin
        w_eff_bits = r_res_bits;
        if (r_res_bits < pwsg_pkg::RES_MIN) begin
            w_eff_bits = pwsg_pkg::RES_MIN;
        end else if (r_res_bits inside {[pwsg_pkg::RES_MAX + 4'd1 : 4'd15]}) begin
            w_eff_bits = pwsg_pkg::RES_MAX;
        end
        n_full = pwsg_pkg::CODE_W'((FULL_W'(1) << w_eff_bits) - FULL_W'(1));
    end

    assign w_idx_ext = EXT_W'(i_sample_index);

    // stage 1: capture item, sine rom read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_rdy1) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_kind <= i_wave_kind;
            r_s1_idx  <= w_idx_ext[IDX_W-1:0];
            r_s1_full <= n_full;
        end
    end

    logic [SINE_FRACTION_BITS-1:0] w_s1_sine;

    pwsg_sine_rom #(
        .SAMPLES   (SAMPLES_PER_PERIOD),
        .FRAC_BITS (SINE_FRACTION_BITS)
    ) u_rom (
        .i_clk     (i_clk),
        .i_rd_en   (w_rdy1),
        .i_rd_addr (w_idx_ext[IDX_W-1:0]),
        .o_rd_data (w_s1_sine)
    );

    // stage 1 to 2: operand select and the one multiply
    logic             w_upper;
    logic [IDX_W:0]   w_mirror;
    logic [OPB_W-1:0] w_opb;
    logic [PROD_W-1:0] w_prod;

    assign w_upper  = r_s1_idx[IDX_W-1];
    assign w_mirror = PERIOD - {1'b0, r_s1_idx};

    always_comb begin
        case (r_s1_kind)
            pwsg_pkg::KIND_SINE: w_opb = OPB_W'(w_s1_sine);
            pwsg_pkg::KIND_TRI:  w_opb = w_upper ? OPB_W'(w_mirror) : OPB_W'(r_s1_idx);
            default:             w_opb = OPB_W'(r_s1_idx);
        endcase
    end

    assign w_prod = PROD_W'(r_s1_full) * PROD_W'(w_opb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_upper <= w_upper;
            r_s2_full  <= r_s1_full;
            r_s2_prod  <= w_prod;
        end
    end

    // stage 2 to output: scale down and pick the code
    logic [PROD_W:0]  w_sine_sum;
    pwsg_pkg::t_code  n_code;

    assign w_sine_sum = {1'b0, r_s2_prod} + SINE_HALF;

    always_comb begin
        case (r_s2_kind)
            pwsg_pkg::KIND_SINE: n_code = pwsg_pkg::CODE_W'(w_sine_sum >> SINE_FRACTION_BITS);
            pwsg_pkg::KIND_TRI:  n_code = pwsg_pkg::CODE_W'(r_s2_prod >> (IDX_W - 1));
            pwsg_pkg::KIND_SAW:  n_code = pwsg_pkg::CODE_W'(r_s2_prod >> IDX_W);
            pwsg_pkg::KIND_SQUARE: n_code = r_s2_upper ? '0 : r_s2_full;
            default:             n_code = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy3) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_out_code <= n_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sample_code = r_out_code;

`ifndef SYNTHESIS
    // input stalls only with every stage occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid && r_out_valid))
        else $error("input stalled with a free pipeline stage");

    // a product held behind a stalled output is not overwritten
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_rdy3) |=> (r_s2_valid && $stable(r_s2_prod)))
        else $error("stage 2 product lost while output stalled");

    // full scale is always an all-ones code of at least one bit
    a_full_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_full[0] == 1'b1))
        else $error("full scale code not clamped to a valid resolution");
`endif

endmodule
